[sv/bsp_pkg.sv]
// Package for the byte stream packer: word geometry constants and the
// beat, result and control structs shared by all packer files.
// Depends on nothing.
`default_nettype none

package bsp_pkg;

   // Word geometry
   localparam int WORD_BYTES = 8;
   localparam int BYTE_W     = 8;
   localparam int DATA_W     = 64;
   localparam int CNT_W      = 4;
   localparam int HOLD_W     = $clog2(WORD_BYTES);
   localparam int SAT_W      = $clog2(WORD_BYTES + 1);
   localparam int TOTAL_W    = $clog2(2 * WORD_BYTES);

   typedef logic [BYTE_W-1:0] byte_type;

   // One input beat
   typedef struct packed {
      logic [DATA_W-1:0] in_word;
      logic [CNT_W-1:0]  in_count;
      logic              in_end;
   } beat_type;

   // One result beat
   typedef struct packed {
      logic [DATA_W-1:0] out_word;
      logic [CNT_W-1:0]  out_count;
      logic              out_end;
      logic              run_last;
   } result_type;

   // Results produced by the merge in the current cycle
   typedef struct packed {
      logic first;
      logic second;
   } push_type;

   // Output stage status seen by the top level
   typedef struct packed {
      logic room;
      logic spill_valid;
   } out_status_type;

endpackage

`default_nettype wire

[sv/bsp_if.sv]
// Valid/ready channel interfaces for the byte stream packer input and result beats.
// Depends on bsp_pkg.
`default_nettype none

interface bsp_req_if;
   logic                        valid;
   logic                        ready;
   logic [bsp_pkg::DATA_W-1:0]  in_word;
   logic [bsp_pkg::CNT_W-1:0]   in_count;
   logic                        in_end;

   modport source (output valid, output in_word, output in_count, output in_end,
                   input ready);
   modport sink   (input valid, input in_word, input in_count, input in_end,
                   output ready);
endinterface

interface bsp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bsp_pkg::DATA_W-1:0]  out_word;
   logic [bsp_pkg::CNT_W-1:0]   out_count;
   logic                        out_end;
   logic                        run_last;

   modport source (output valid, output out_word, output out_count, output out_end,
                   output run_last, input ready);
   modport sink   (input valid, input out_word, input out_count, input out_end,
                   input run_last, output ready);
endinterface

`default_nettype wire

[sv/bsp_merge.sv]
// Merge stage: holding word plus byte alignment of each beat into full and
// remainder words. Depends on bsp_pkg.
`default_nettype none

module bsp_merge (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire bsp_pkg::beat_type beat,
   output bsp_pkg::result_type    res0,
   output bsp_pkg::result_type    res1,
   output bsp_pkg::push_type      push
);

   bsp_pkg::byte_type                 hold_ff     [bsp_pkg::WORD_BYTES];
   bsp_pkg::byte_type                 hold_in     [bsp_pkg::WORD_BYTES];
   logic [bsp_pkg::HOLD_W-1:0]        hold_count_ff;
   logic [bsp_pkg::HOLD_W-1:0]        hold_count_in;

   bsp_pkg::byte_type                 in_bytes    [bsp_pkg::WORD_BYTES];
   bsp_pkg::byte_type                 merged      [2 * bsp_pkg::WORD_BYTES];
   logic [bsp_pkg::SAT_W-1:0]         cnt_sat;
   logic [bsp_pkg::TOTAL_W-1:0]       total;
   logic [bsp_pkg::TOTAL_W-1:0]       rem;
   logic                              full;
   logic [bsp_pkg::DATA_W-1:0]        lo_word;
   logic [bsp_pkg::DATA_W-1:0]        hi_word;

   // Saturate the count and split the input into bytes
   always_comb begin
      for (int i = 0; i < bsp_pkg::WORD_BYTES; i++) begin
         in_bytes[i] = beat.in_word[bsp_pkg::BYTE_W*i +: bsp_pkg::BYTE_W];
      end
      if (beat.in_count > bsp_pkg::CNT_W'(bsp_pkg::WORD_BYTES)) begin
         cnt_sat = bsp_pkg::SAT_W'(bsp_pkg::WORD_BYTES);
      end else begin
         cnt_sat = bsp_pkg::SAT_W'(beat.in_count);
      end
      total = bsp_pkg::TOTAL_W'(hold_count_ff) + bsp_pkg::TOTAL_W'(cnt_sat);
   end

   // Append the valid input bytes behind the held bytes
   always_comb begin
      logic [bsp_pkg::TOTAL_W-1:0] jj;
      logic [bsp_pkg::TOTAL_W-1:0] k;
      for (int j = 0; j < 2 * bsp_pkg::WORD_BYTES; j++) begin
         jj = bsp_pkg::TOTAL_W'(j);
         k  = jj - bsp_pkg::TOTAL_W'(hold_count_ff);
         if (jj < bsp_pkg::TOTAL_W'(hold_count_ff)) begin
            merged[j] = hold_ff[jj[bsp_pkg::HOLD_W-1:0]];
         end else if (k < bsp_pkg::TOTAL_W'(cnt_sat)) begin
            merged[j] = in_bytes[k[bsp_pkg::HOLD_W-1:0]];
         end else begin
            merged[j] = '0;
         end
      end
   end

   // Pack the lower and upper halves; bytes past the word stay zero
   always_comb begin
      lo_word = '0;
      hi_word = '0;
      for (int i = 0; i < bsp_pkg::WORD_BYTES; i++) begin
         lo_word[bsp_pkg::BYTE_W*i +: bsp_pkg::BYTE_W] = merged[i];
         hi_word[bsp_pkg::BYTE_W*i +: bsp_pkg::BYTE_W] = merged[bsp_pkg::WORD_BYTES + i];
      end
   end

   // Build the results and the next holding word
   always_comb begin
      full = total >= bsp_pkg::TOTAL_W'(bsp_pkg::WORD_BYTES);
      rem  = total - bsp_pkg::TOTAL_W'(bsp_pkg::WORD_BYTES);

      res0 = '0;
      res1 = '0;
      push = '0;

      res1.out_word  = hi_word;
      res1.out_count = bsp_pkg::CNT_W'(rem);
      res1.out_end   = 1'b1;
      res1.run_last  = 1'b1;

      if (full) begin
         res0.out_word  = lo_word;
         res0.out_count = bsp_pkg::CNT_W'(bsp_pkg::WORD_BYTES);
         push.first     = fire;
         if (beat.in_end && rem != '0) begin
            res0.out_end  = 1'b0;
            res0.run_last = 1'b0;
            push.second   = fire;
         end else begin
            res0.out_end  = beat.in_end;
            res0.run_last = 1'b1;
         end
      end else begin
         res0.out_word  = lo_word;
         res0.out_count = bsp_pkg::CNT_W'(total);
         res0.out_end   = 1'b1;
         res0.run_last  = 1'b1;
         push.first     = fire & beat.in_end;
      end

      for (int i = 0; i < bsp_pkg::WORD_BYTES; i++) begin
         if (beat.in_end) begin
            hold_in[i] = '0;
         end else if (full) begin
            hold_in[i] = merged[bsp_pkg::WORD_BYTES + i];
         end else begin
            hold_in[i] = merged[i];
         end
      end
      if (beat.in_end) begin
         hold_count_in = '0;
      end else if (full) begin
         hold_count_in = bsp_pkg::HOLD_W'(rem);
      end else begin
         hold_count_in = bsp_pkg::HOLD_W'(total);
      end
   end

   // Advance the holding count
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_count_ff <= '0;
      end else if (fire) begin
         hold_count_ff <= hold_count_in;
      end
   end

   // Hold bytes; only bytes below the count are ever read
   always_ff @(posedge clock) begin
      if (fire) begin
         hold_ff <= hold_in;
      end
   end

endmodule

`default_nettype wire

[sv/bsp_out_stage.sv]
// Result register with one spill slot for the second word of a packet end.
// Depends on bsp_pkg.
`default_nettype none

module bsp_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bsp_pkg::push_type    push,
   input  wire bsp_pkg::result_type  res0,
   input  wire bsp_pkg::result_type  res1,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output bsp_pkg::result_type       rsp_data,
   output bsp_pkg::out_status_type   status
);

   logic                 out_valid_ff;
   logic                 out_valid_in;
   bsp_pkg::result_type  out_ff;
   bsp_pkg::result_type  out_in;
   logic                 spill_valid_ff;
   logic                 spill_valid_in;
   bsp_pkg::result_type  spill_ff;
   logic                 take;
   logic                 out_free;
   logic                 load_out;

   assign take     = out_valid_ff & rsp_ready;
   assign out_free = ~out_valid_ff | take;

   // Move the spill forward first, then new results, else drain
   always_comb begin
      out_valid_in   = out_valid_ff;
      spill_valid_in = spill_valid_ff;
      out_in         = out_ff;
      load_out       = 1'b0;
      priority if (spill_valid_ff && out_free) begin
         out_in         = spill_ff;
         out_valid_in   = 1'b1;
         spill_valid_in = 1'b0;
         load_out       = 1'b1;
      end else if (push.first) begin
         out_in         = res0;
         out_valid_in   = 1'b1;
         spill_valid_in = push.second;
         load_out       = 1'b1;
      end else if (take) begin
         out_valid_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         spill_valid_ff <= 1'b0;
      end else begin
         out_valid_ff   <= out_valid_in;
         spill_valid_ff <= spill_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (load_out) begin
         out_ff <= out_in;
      end
      if (push.second) begin
         spill_ff <= res1;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_data           = out_ff;
   assign status.room        = ~spill_valid_ff & out_free;
   assign status.spill_valid = spill_valid_ff;

endmodule

`default_nettype wire

[sv/byte_stream_packer.sv]
// Byte stream packer: appends the valid leading bytes of each input beat to
// a holding word and sends out full 8-byte words, plus the partial remainder
// at end of packet with its count, zero bytes past the count. A beat can be
// taken every cycle while the output side has room; its results go through
// the input register, then the result register. A beat that overfills the
// word at a packet end gives two words and the single spill slot behind the
// result register then holds the next beat back while full. No clearing pass
// after reset. Depends on bsp_pkg, bsp_if, bsp_merge and bsp_out_stage.
`default_nettype none

module byte_stream_packer (
   input  wire logic  clock,
   input  wire logic  reset,
   bsp_req_if.sink    req_ch,
   bsp_rsp_if.source  rsp_ch
);

   logic                          in_valid_ff;
   logic                          in_valid_in;
   bsp_pkg::beat_type             beat_ff;
   logic                          fire;
   logic                          req_take;
   bsp_pkg::push_type             push;
   bsp_pkg::result_type           res0;
   bsp_pkg::result_type           res1;
   bsp_pkg::result_type           rsp_data;
   bsp_pkg::out_status_type       status;

   // Process the registered beat when the output side has room
   assign fire         = in_valid_ff & status.room;
   assign req_ch.ready = ~in_valid_ff | fire;
   assign req_take     = req_ch.valid & req_ch.ready;
   assign in_valid_in  = req_take | (in_valid_ff & ~fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Capture the input beat
   always_ff @(posedge clock) begin
      if (req_take) begin
         beat_ff.in_word  <= req_ch.in_word;
         beat_ff.in_count <= req_ch.in_count;
         beat_ff.in_end   <= req_ch.in_end;
      end
   end

   bsp_merge u_merge (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .beat  (beat_ff),
      .res0  (res0),
      .res1  (res1),
      .push  (push)
   );

   bsp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .res0      (res0),
      .res1      (res1),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_data  (rsp_data),
      .status    (status)
   );

   assign rsp_ch.out_word  = rsp_data.out_word;
   assign rsp_ch.out_count = rsp_data.out_count;
   assign rsp_ch.out_end   = rsp_data.out_end;
   assign rsp_ch.run_last  = rsp_data.run_last;

`ifndef ASSERT_OFF
   // A spilled word always sits behind a shown word
   a_spill_behind_out: assert property (@(posedge clock) disable iff (reset)
      status.spill_valid |-> rsp_ch.valid)
      else $error("spill slot valid with empty result register");

   // A two-word beat leaves its second word in the spill slot
   a_two_word_spill: assert property (@(posedge clock) disable iff (reset)
      (push.first && push.second) |=> status.spill_valid)
      else $error("second word of a beat was not held");

   // A shown word that is not the beat's last has its follower waiting
   a_follower_waits: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.run_last) |-> status.spill_valid)
      else $error("first word shown without its follower");

   // The second word never comes without the first
   a_second_needs_first: assert property (@(posedge clock) disable iff (reset)
      push.second |-> (push.first && fire))
      else $error("second word pushed alone");
`endif

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Testbench for byte_stream_packer: drives input beats, predicts the packed words and checks
// every result beat in order. Depends on bsp_pkg, bsp_if and the packer RTL.
`timescale 1ns / 100ps

module testbench;
   import bsp_pkg::*;

   logic clock = 1'b0;
   logic reset;

   bsp_req_if req_ch ();
   bsp_rsp_if rsp_ch ();

   byte_stream_packer u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Packer image: holding word (bytes past the count are zero) and its byte count
   logic [DATA_W-1:0] held_word;
   logic [CNT_W-1:0]  held_count;

   result_type pending_words[$];
   int         error_count = 0;
   int         beats_sent  = 0;
   bit         calm        = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("testbench: done, errors");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      begin
         error_count++;
         $display("%0t mismatch: %s got %h expected %h", $realtime, what, got, want);
      end
   endtask

   // Append the valid bytes of one beat and queue the words it completes
   task automatic predict_words(input beat_type b);
      logic [2*DATA_W-1:0] merged;
      logic [DATA_W-1:0]   taken;
      int                  cnt;
      int                  total;
      int                  rem;
      result_type          r;
      begin
         cnt   = (b.in_count > WORD_BYTES) ? WORD_BYTES : int'(b.in_count);
         taken = '0;
         for (int i = 0; i < cnt; i++)
            taken[BYTE_W*i +: BYTE_W] = b.in_word[BYTE_W*i +: BYTE_W];
         merged = {{DATA_W{1'b0}}, held_word}
                | ({{DATA_W{1'b0}}, taken} << (BYTE_W * held_count));
         total  = int'(held_count) + cnt;
         if (total >= WORD_BYTES) begin
            rem = total - WORD_BYTES;
            r = '{out_word: merged[DATA_W-1:0], out_count: CNT_W'(WORD_BYTES),
                  out_end: b.in_end && rem == 0, run_last: !(b.in_end && rem > 0)};
            pending_words.push_back(r);
            if (b.in_end && rem > 0) begin
               r = '{out_word: merged[2*DATA_W-1:DATA_W], out_count: CNT_W'(rem),
                     out_end: 1'b1, run_last: 1'b1};
               pending_words.push_back(r);
            end
            held_word  = b.in_end ? '0 : merged[2*DATA_W-1:DATA_W];
            held_count = b.in_end ? '0 : CNT_W'(rem);
         end else if (b.in_end) begin
            r = '{out_word: merged[DATA_W-1:0], out_count: CNT_W'(total),
                  out_end: 1'b1, run_last: 1'b1};
            pending_words.push_back(r);
            held_word  = '0;
            held_count = '0;
         end else begin
            held_word  = merged[DATA_W-1:0];
            held_count = CNT_W'(total);
         end
      end
   endtask

   // Predict on accepted input beats, compare accepted result beats with the oldest word
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         held_word  = '0;
         held_count = '0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            predict_words('{in_word: req_ch.in_word, in_count: req_ch.in_count,
                            in_end: req_ch.in_end});
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_words.size() == 0) begin
               report_mismatch("unexpected result beat, word", rsp_ch.out_word, '0);
            end else begin
               want = pending_words.pop_front();
               if (rsp_ch.out_word !== want.out_word)
                  report_mismatch("out_word", rsp_ch.out_word, want.out_word);
               if (rsp_ch.out_count !== want.out_count)
                  report_mismatch("out_count", rsp_ch.out_count, want.out_count);
               if (rsp_ch.out_end !== want.out_end)
                  report_mismatch("out_end", rsp_ch.out_end, want.out_end);
               if (rsp_ch.run_last !== want.run_last)
                  report_mismatch("run_last", rsp_ch.run_last, want.run_last);
            end
         end
      end
   end

   // Stall the result side at random, never while calm
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 28);
      end
   end

   // Present one beat after random idle cycles and hold it until accepted
   task automatic send_beat(input logic [DATA_W-1:0] w, input logic [CNT_W-1:0] c,
                            input logic e);
      begin
         while (!calm && $urandom_range(0, 99) < 28) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
         end
         req_ch.valid    <= 1'b1;
         req_ch.in_word  <= w;
         req_ch.in_count <= c;
         req_ch.in_end   <= e;
         do
            @(posedge clock);
         while (!req_ch.ready);
         beats_sent++;
      end
   endtask

   function automatic logic [DATA_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Field extremes and each corner of the merge
   task automatic test_directed();
      begin
         send_beat('1, 4'd0, 1'b0);                       // no bytes, nothing held
         send_beat('1, 4'd0, 1'b1);                       // empty end
         send_beat(64'h0123_4567_89ab_cdef, 4'd8, 1'b0);  // one full word
         send_beat('1, 4'd15, 1'b0);                      // count saturates
         send_beat('1, 4'd9, 1'b1);                       // saturated, fills exactly at end
         send_beat({32{2'b10}}, 4'd3, 1'b0);              // bytes past the count ignored
         send_beat({32{2'b01}}, 4'd5, 1'b1);              // fills exactly at end
         send_beat(64'hfedc_ba98_7654_3210, 4'd5, 1'b0);
         send_beat(64'h1122_3344_5566_7788, 4'd6, 1'b1);  // overfills at end
         send_beat(random_word(), 4'd7, 1'b0);
         send_beat(random_word(), 4'd1, 1'b0);            // fills without end
         send_beat(random_word(), 4'd7, 1'b0);
         send_beat(random_word(), 4'd7, 1'b0);            // fills and carries six bytes
         send_beat('1, 4'd0, 1'b1);                       // flush of the carried bytes
         send_beat(random_word(), 4'd1, 1'b1);            // one-byte packet
         send_beat(random_word(), 4'd4, 1'b0);
         send_beat('1, 4'd12, 1'b1);                      // saturated overfill at end
         send_beat('0, 4'd0, 1'b0);
         send_beat('0, 4'd8, 1'b1);
         send_beat(random_word(), 4'd2, 1'b0);
         send_beat(random_word(), 4'd14, 1'b1);
      end
   endtask

   // Well-formed packets with random lengths and contents
   task automatic test_packets(input int beats);
      int stop;
      int n;
      logic [CNT_W-1:0] c;
      begin
         stop = beats_sent + beats;
         while (beats_sent < stop) begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
               c = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(9, 15))
                                              : CNT_W'($urandom_range(0, 8));
               send_beat(random_word(), c, i == n - 1);
            end
         end
      end
   endtask

   // Back-to-back beats with both sides always ready
   task automatic test_steady_stream(input int beats);
      begin
         calm = 1'b1;
         test_packets(beats);
         calm = 1'b0;
      end
   endtask

   // Arbitrary fields: random ends and out-of-range counts
   task automatic test_noise(input int beats);
      begin
         repeat (beats)
            send_beat(random_word(), CNT_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic drain_results();
      int waited;
      begin
         req_ch.valid <= 1'b0;
         waited = 0;
         while (pending_words.size() != 0 && waited < 20_000) begin
            @(posedge clock);
            waited++;
         end
         repeat (10) @(posedge clock);
         while (pending_words.size() != 0)
            report_mismatch("missing result beat, word", '0, pending_words.pop_front().out_word);
      end
   endtask

   initial begin
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.in_word  <= '0;
      req_ch.in_count <= '0;
      req_ch.in_end   <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_packets(330);
      test_steady_stream(150);
      test_noise(150);
      test_packets(150);
      drain_results();

      if (error_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

[filelist.f]
sv/bsp_pkg.sv
sv/bsp_if.sv
sv/bsp_merge.sv
sv/bsp_out_stage.sv
sv/byte_stream_packer.sv
tb/sv/testbench.sv
